### rtl/assert_macros.svh
// assertion macros used by the checker file bdm_checker.sv
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define BDM_ASSERT_IMP(LBL, CK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CK) disable iff (!(RSTN)) (ANTE) |-> (CONS)) \
    else $error(MSG);

// next-cycle implication, reset masks the check
`define BDM_ASSERT_NXT(LBL, CK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CK) disable iff (!(RSTN)) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

### rtl/bdm_pkg.sv
// shared types, codes and sizes of the button debounce / midi event block
// no dependencies; used by the top, bdm_decode and bdm_checker through scoped names
package bdm_pkg;

  localparam int NUM_BUTTONS  = 64;
  localparam int BTN_IDX_W    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int NUM_CHANNELS = 16;

  localparam logic [6:0] PROG_MAX   = 7'd127;
  localparam logic [7:0] MASK_RESET = 8'hF0;
  localparam logic [7:0] HIST_FULL  = 8'hFF;

  // register select (word address bit of paddr)
  localparam logic REG_DEBOUNCE_MASK = 1'b0;

  // opcodes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_SETTING = 1'b1;

  // setting fields
  localparam logic [2:0] FLD_KIND     = 3'd0;
  localparam logic [2:0] FLD_LATCHING = 3'd1;
  localparam logic [2:0] FLD_MIDI_ID  = 3'd2;
  localparam logic [2:0] FLD_CHANNEL  = 3'd3;
  localparam logic [2:0] FLD_VELOCITY = 3'd4;
  localparam logic [2:0] FLD_SKIP     = 3'd5;

  // message kinds
  localparam logic [6:0] KIND_NONE      = 7'd0;
  localparam logic [6:0] KIND_NOTE      = 7'd1;
  localparam logic [6:0] KIND_PROG      = 7'd2;
  localparam logic [6:0] KIND_PROG_INC  = 7'd3;
  localparam logic [6:0] KIND_PROG_DEC  = 7'd4;
  localparam logic [6:0] KIND_CC        = 7'd5;
  localparam logic [6:0] KIND_CC_RESET  = 7'd6;
  localparam logic [6:0] KIND_MMC_PLAY  = 7'd7;
  localparam logic [6:0] KIND_MMC_STOP  = 7'd8;
  localparam logic [6:0] KIND_MMC_PAUSE = 7'd9;
  localparam logic [6:0] KIND_MMC_REC   = 7'd10;
  localparam logic [6:0] KIND_RT_CLOCK  = 7'd11;
  localparam logic [6:0] KIND_RT_START  = 7'd12;
  localparam logic [6:0] KIND_RT_CONT   = 7'd13;
  localparam logic [6:0] KIND_RT_STOP   = 7'd14;
  localparam logic [6:0] KIND_RT_SENSE  = 7'd15;
  localparam logic [6:0] KIND_RT_RESET  = 7'd16;
  localparam logic [6:0] KIND_PRESET    = 7'd17;
  localparam logic [6:0] KIND_HOOK      = 7'd18;

  // result actions
  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_NOTE_ON  = 4'd1;
  localparam logic [3:0] ACT_NOTE_OFF = 4'd2;
  localparam logic [3:0] ACT_PROG     = 4'd3;
  localparam logic [3:0] ACT_CC       = 4'd4;
  localparam logic [3:0] ACT_MMC      = 4'd5;
  localparam logic [3:0] ACT_RT       = 4'd6;
  localparam logic [3:0] ACT_PRESET   = 4'd7;
  localparam logic [3:0] ACT_HOOK     = 4'd8;

  // mmc commands and realtime status bytes
  localparam logic [7:0] MMC_PLAY    = 8'h02;
  localparam logic [7:0] MMC_STOP    = 8'h01;
  localparam logic [7:0] MMC_PAUSE   = 8'h09;
  localparam logic [7:0] MMC_REC_ON  = 8'h06;
  localparam logic [7:0] MMC_REC_OFF = 8'h07;
  localparam logic [7:0] RT_CLOCK    = 8'hF8;
  localparam logic [7:0] RT_START    = 8'hFA;
  localparam logic [7:0] RT_CONT     = 8'hFB;
  localparam logic [7:0] RT_STOP     = 8'hFC;
  localparam logic [7:0] RT_SENSE    = 8'hFE;
  localparam logic [7:0] RT_RESET    = 8'hFF;

  typedef struct packed {
    logic [6:0] kind;
    logic       latching;
    logic [6:0] midi_id;
    logic [3:0] channel;
    logic [6:0] velocity;
    logic       skip;
  } setting_t;

  // one memory word per button
  typedef struct packed {
    logic [7:0] history;
    logic       pressed;
    logic       latched;
    setting_t   cfg;
  } btn_rec_t;

  localparam int REC_W = $bits(btn_rec_t);

  // outcome of one transaction, decode -> top
  typedef struct packed {
    btn_rec_t   rec_nxt;
    logic       wr;
    logic       res_vld;
    logic       need_prog;
    logic       prog_dec;
    logic       state;
    logic [3:0] action;
    logic [6:0] data_one;
    logic [7:0] data_two;
    logic [3:0] chan;
  } eval_t;

endpackage

### rtl/button_debounce_midi_event.sv
// top level of the button debounce / midi event block
// depends on bdm_pkg, bdm_ram, bdm_decode
//
// One transaction on start/busy is either a raw sample of one button or a
// write of one of its settings. In a sample or setting write,
// the button's word (history, debounced bit, latch bit, settings) is read
// from the button ram in the accept cycle and decoded and written back in
// the next, while busy is high. Program increment/decrement events add an
// S_PROG state, since the per-channel program ram can only be addressed once
// the channel setting has come out of the button ram. A new transaction
// is accepted only while busy is low, after S_EXEC or S_PROG. A result,
// when there is one, shows on the out_ ports for exactly one cycle with
// out_valid high, in the first cycle with busy low again; the receiver must
// take it then, there is no back-pressure. At most one result per transaction.
// Reset clears the valid bits of both rams at once, so every button word
// and program value reads as zero right after reset with no clearing pass.
// debounce_mask (reset 0xF0) sits at byte address 0 of the apb port and
// must only be written while the block is idle.
module button_debounce_midi_event (
  input  logic        clk,
  input  logic        rst_n,
  // sample / setting transactions
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [5:0]  in_button,
  input  logic        in_level,
  input  logic [2:0]  in_setting_field,
  input  logic [6:0]  in_setting_value,
  // event results
  output logic        out_valid,
  output logic [5:0]  out_button_out,
  output logic        out_reported_state,
  output logic [3:0]  out_action,
  output logic [6:0]  out_data_one,
  output logic [7:0]  out_data_two,
  output logic [3:0]  out_midi_channel,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PROG
  } state_t;

  state_t     state_r;

  // latched transaction
  logic       op_r;
  logic       lvl_r;
  logic [2:0] fld_r;
  logic [6:0] val_r;
  logic [5:0] btn_r;
  logic       dec_r;

  logic [7:0] mask_r;

  logic       out_valid_r;
  logic [5:0] out_button_r;
  logic       out_state_r;
  logic [3:0] out_action_r;
  logic [6:0] out_d1_r;
  logic [7:0] out_d2_r;
  logic [3:0] out_chan_r;

  logic                      accept;
  logic                      in_range;
  logic [bdm_pkg::REC_W-1:0] btn_rd_data;
  bdm_pkg::btn_rec_t         rec;
  bdm_pkg::eval_t            ev;
  logic [6:0]                prog_rd_data;
  logic [6:0]                prog_nxt;
  logic                      mask_wr;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  // buttons past the configured count are dropped at the door
  assign in_range = ({3'b000, in_button} < 9'(bdm_pkg::NUM_BUTTONS));

  // ---------------------------------------------------------------------
  // apb register: debounce mask
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign mask_wr = psel && penable && pwrite && pready &&
                   (paddr[2] == bdm_pkg::REG_DEBOUNCE_MASK);
  assign prdata  = (paddr[2] == bdm_pkg::REG_DEBOUNCE_MASK) ? {24'd0, mask_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= bdm_pkg::MASK_RESET;
    end else if (mask_wr) begin
      mask_r <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------
  // button ram: read at accept, written back in the exec cycle
  // busy keeps the next read away until the write-back is done
  // ---------------------------------------------------------------------
  bdm_ram #(
    .WIDTH (bdm_pkg::REC_W),
    .DEPTH (bdm_pkg::NUM_BUTTONS)
  ) u_btn_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (bdm_pkg::BTN_IDX_W'(in_button)),
    .rd_data (btn_rd_data),
    .wr_en   ((state_r == S_EXEC) && ev.wr),
    .wr_addr (bdm_pkg::BTN_IDX_W'(btn_r)),
    .wr_data (ev.rec_nxt)
  );

  assign rec = bdm_pkg::btn_rec_t'(btn_rd_data);

  bdm_decode u_decode (
    .opcode (op_r),
    .level  (lvl_r),
    .field  (fld_r),
    .value  (val_r),
    .mask   (mask_r),
    .rec    (rec),
    .ev     (ev)
  );

  // ---------------------------------------------------------------------
  // per-channel program ram: read in exec at the button's channel,
  // saturating inc/dec written back in the following cycle
  // ---------------------------------------------------------------------
  bdm_ram #(
    .WIDTH (7),
    .DEPTH (bdm_pkg::NUM_CHANNELS)
  ) u_prog_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   ((state_r == S_EXEC) && ev.need_prog),
    .rd_addr (ev.chan),
    .rd_data (prog_rd_data),
    .wr_en   (state_r == S_PROG),
    .wr_addr (out_chan_r),
    .wr_data (prog_nxt)
  );

  always_comb begin
    if (dec_r) begin
      prog_nxt = (prog_rd_data != 7'd0) ? (prog_rd_data - 7'd1) : prog_rd_data;
    end else begin
      prog_nxt = (prog_rd_data != bdm_pkg::PROG_MAX) ? (prog_rd_data + 7'd1) : prog_rd_data;
    end
  end

  // ---------------------------------------------------------------------
  // sequencer and registered result
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && in_range) begin
            op_r    <= in_opcode;
            lvl_r   <= in_level;
            fld_r   <= in_setting_field;
            val_r   <= in_setting_value;
            btn_r   <= in_button;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          // result payload loaded always; only the strobe marks it
          out_button_r <= btn_r;
          out_state_r  <= ev.state;
          out_action_r <= ev.action;
          out_d1_r     <= ev.data_one;
          out_d2_r     <= ev.data_two;
          out_chan_r   <= ev.chan;
          dec_r        <= ev.prog_dec;
          if (ev.res_vld && ev.need_prog) begin
            state_r <= S_PROG;
          end else begin
            out_valid_r <= ev.res_vld;
            state_r     <= S_IDLE;
          end
        end
        S_PROG: begin
          out_d1_r    <= prog_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_button_out     = out_button_r;
  assign out_reported_state = out_state_r;
  assign out_action         = out_action_r;
  assign out_data_one       = out_d1_r;
  assign out_data_two       = out_d2_r;
  assign out_midi_channel   = out_chan_r;

endmodule

### rtl/bdm_ram.sv
// single-port-write / single-port-read synchronous ram with registered read data
// per-entry valid bits cleared by reset, an unwritten entry reads as zero
// no dependencies
module bdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/bdm_decode.sv
// per-transaction update of one button word and coding of its midi event
// depends on bdm_pkg
module bdm_decode (
  input  logic              opcode,
  input  logic              level,
  input  logic [2:0]        field,
  input  logic [6:0]        value,
  input  logic [7:0]        mask,
  input  bdm_pkg::btn_rec_t rec,
  output bdm_pkg::eval_t    ev
);

  logic [7:0] hist_new;
  logic       stable;
  logic       forced_mom;
  logic       latching;
  logic [6:0] kind;

  assign kind     = rec.cfg.kind;
  assign hist_new = {rec.history[6:0], level} | mask;
  assign stable   = (hist_new == mask) || (hist_new == bdm_pkg::HIST_FULL);

  assign forced_mom =
      ((kind >= bdm_pkg::KIND_PROG)     && (kind <= bdm_pkg::KIND_CC))        ||
      ((kind >= bdm_pkg::KIND_MMC_PLAY) && (kind <= bdm_pkg::KIND_MMC_PAUSE)) ||
      ((kind >= bdm_pkg::KIND_RT_CLOCK) && (kind <= bdm_pkg::KIND_PRESET));
  assign latching = (kind == bdm_pkg::KIND_MMC_REC) ? 1'b1 :
                    forced_mom ? 1'b0 : rec.cfg.latching;

  always_comb begin
    logic emit;
    emit       = 1'b1;
    ev         = '0;
    ev.rec_nxt = rec;
    ev.chan    = rec.cfg.channel;

    if (opcode == bdm_pkg::OP_SETTING) begin
      ev.wr = 1'b1;
      case (field)
        bdm_pkg::FLD_KIND:     ev.rec_nxt.cfg.kind     = value;
        bdm_pkg::FLD_LATCHING: ev.rec_nxt.cfg.latching = value[0];
        bdm_pkg::FLD_MIDI_ID:  ev.rec_nxt.cfg.midi_id  = value;
        bdm_pkg::FLD_CHANNEL:  ev.rec_nxt.cfg.channel  = value[3:0];
        bdm_pkg::FLD_VELOCITY: ev.rec_nxt.cfg.velocity = value;
        bdm_pkg::FLD_SKIP:     ev.rec_nxt.cfg.skip     = value[0];
        default:               ev.wr                   = 1'b0;
      endcase
    end else if (!rec.cfg.skip) begin
      ev.wr              = 1'b1;
      ev.rec_nxt.history = hist_new;
      if (stable && (level != rec.pressed)) begin
        ev.rec_nxt.pressed = level;
        ev.res_vld         = 1'b1;
        ev.state           = level;
        if (kind != bdm_pkg::KIND_NONE) begin
          if (latching) begin
            if (level) begin
              ev.rec_nxt.latched = ~rec.latched;
              ev.state           = ~rec.latched;
            end else begin
              ev.state = rec.latched;
              emit     = 1'b0;
            end
          end

          if (kind == bdm_pkg::KIND_HOOK) begin
            ev.action = bdm_pkg::ACT_HOOK;
          end else if (kind == bdm_pkg::KIND_PRESET) begin
            ev.action   = bdm_pkg::ACT_PRESET;
            ev.data_one = rec.cfg.midi_id;
          end else if (emit && ev.state) begin
            case (kind)
              bdm_pkg::KIND_NOTE: begin
                ev.action   = bdm_pkg::ACT_NOTE_ON;
                ev.data_one = rec.cfg.midi_id;
                ev.data_two = {1'b0, rec.cfg.velocity};
              end
              bdm_pkg::KIND_PROG: begin
                ev.action   = bdm_pkg::ACT_PROG;
                ev.data_one = rec.cfg.midi_id;
              end
              bdm_pkg::KIND_PROG_INC: begin
                ev.action    = bdm_pkg::ACT_PROG;
                ev.need_prog = 1'b1;
              end
              bdm_pkg::KIND_PROG_DEC: begin
                ev.action    = bdm_pkg::ACT_PROG;
                ev.need_prog = 1'b1;
                ev.prog_dec  = 1'b1;
              end
              bdm_pkg::KIND_CC, bdm_pkg::KIND_CC_RESET: begin
                ev.action   = bdm_pkg::ACT_CC;
                ev.data_one = rec.cfg.midi_id;
                ev.data_two = {1'b0, rec.cfg.velocity};
              end
              bdm_pkg::KIND_MMC_PLAY: begin
                ev.action   = bdm_pkg::ACT_MMC;
                ev.data_one = rec.cfg.midi_id;
                ev.data_two = bdm_pkg::MMC_PLAY;
              end
              bdm_pkg::KIND_MMC_STOP: begin
                ev.action   = bdm_pkg::ACT_MMC;
                ev.data_one = rec.cfg.midi_id;
                ev.data_two = bdm_pkg::MMC_STOP;
              end
              bdm_pkg::KIND_MMC_PAUSE: begin
                ev.action   = bdm_pkg::ACT_MMC;
                ev.data_one = rec.cfg.midi_id;
                ev.data_two = bdm_pkg::MMC_PAUSE;
              end
              bdm_pkg::KIND_MMC_REC: begin
                ev.action   = bdm_pkg::ACT_MMC;
                ev.data_one = rec.cfg.midi_id;
                ev.data_two = bdm_pkg::MMC_REC_ON;
              end
              bdm_pkg::KIND_RT_CLOCK: begin
                ev.action   = bdm_pkg::ACT_RT;
                ev.data_two = bdm_pkg::RT_CLOCK;
              end
              bdm_pkg::KIND_RT_START: begin
                ev.action   = bdm_pkg::ACT_RT;
                ev.data_two = bdm_pkg::RT_START;
              end
              bdm_pkg::KIND_RT_CONT: begin
                ev.action   = bdm_pkg::ACT_RT;
                ev.data_two = bdm_pkg::RT_CONT;
              end
              bdm_pkg::KIND_RT_STOP: begin
                ev.action   = bdm_pkg::ACT_RT;
                ev.data_two = bdm_pkg::RT_STOP;
              end
              bdm_pkg::KIND_RT_SENSE: begin
                ev.action   = bdm_pkg::ACT_RT;
                ev.data_two = bdm_pkg::RT_SENSE;
              end
              bdm_pkg::KIND_RT_RESET: begin
                ev.action   = bdm_pkg::ACT_RT;
                ev.data_two = bdm_pkg::RT_RESET;
              end
              default: ev.action = bdm_pkg::ACT_NONE;
            endcase
          end else if (emit) begin
            case (kind)
              bdm_pkg::KIND_NOTE: begin
                ev.action   = bdm_pkg::ACT_NOTE_OFF;
                ev.data_one = rec.cfg.midi_id;
              end
              bdm_pkg::KIND_CC_RESET: begin
                ev.action   = bdm_pkg::ACT_CC;
                ev.data_one = rec.cfg.midi_id;
              end
              bdm_pkg::KIND_MMC_REC: begin
                ev.action   = bdm_pkg::ACT_MMC;
                ev.data_one = rec.cfg.midi_id;
                ev.data_two = bdm_pkg::MMC_REC_OFF;
              end
              default: ev.action = bdm_pkg::ACT_NONE;
            endcase
          end
        end
      end
    end
  end

endmodule

### rtl/bdm_checker.sv
// port-level checks of the button debounce / midi event block, bound to the top
// depends on bdm_pkg and assert_macros.svh
`include "assert_macros.svh"

module bdm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [3:0]  out_action,
  input logic [31:0] prdata
);

  // every transaction passes through S_EXEC with busy high, so strobes never touch
  `BDM_ASSERT_NXT(a_no_back_to_back, clk, rst_n, out_valid, !out_valid, "results back to back")

  // a result closes a busy period
  `BDM_ASSERT_IMP(a_res_after_busy, clk, rst_n, out_valid, $past(busy), "result without work")

  // result strobe and busy are never seen together
  `BDM_ASSERT_IMP(a_res_idle, clk, rst_n, out_valid, !busy, "result while busy")

  // only defined action codes leave the block
  `BDM_ASSERT_IMP(a_action_code, clk, rst_n, out_valid, out_action <= bdm_pkg::ACT_HOOK, "bad action")

  // the mask register is 8 bits wide
  `BDM_ASSERT_IMP(a_prdata_width, clk, rst_n, 1'b1, prdata[31:8] == 24'd0, "prdata high bits set")

endmodule

bind button_debounce_midi_event bdm_checker u_bdm_checker (.*);
